>>> hdl/ppc_pkg.sv
// Shared types and codes for the pulse position calibrator.
// Holds the request and result structs, the controller command and status structs.
// Depends on nothing.
package ppc_pkg;

    typedef struct packed {
        logic signed [31:0] pulse_count;
        logic signed [31:0] cal_pos_one;
        logic               cal_order_one;
        logic signed [31:0] cal_pos_two;
        logic               cal_order_two;
    } ppc_in_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [47:0] gain_now;
        logic        [1:0]  cal_event;
    } ppc_out_t;

    localparam logic [1:0] EVT_NONE       = 2'd0;
    localparam logic [1:0] EVT_POINT_ONE  = 2'd1;
    localparam logic [1:0] EVT_POINT_TWO  = 2'd2;
    localparam logic [1:0] EVT_REJECT     = 2'd3;

    typedef enum logic [1:0] {
        OP_POINT_ONE = 2'd0,
        OP_GAIN      = 2'd1,
        OP_REJECT    = 2'd2,
        OP_APPLY     = 2'd3
    } ppc_op_t;

    typedef struct packed {
        logic    load_in;
        logic    eval;
        logic    div_step;
        logic    mul_hi;
        logic    scale;
        logic    commit;
        ppc_op_t op;
    } ppc_cmd_t;

    typedef struct packed {
        logic edge_one;
        logic edge_two;
        logic diff_ok;
        logic div_last;
        logic out_free;
    } ppc_status_t;

endpackage

>>> hdl/ppc_ctrl.sv
// Controller state machine of the pulse position calibrator.
// Sequences the datapath through evaluation, then division, multiplication or neither, and commit.
// Depends on ppc_pkg.
module ppc_ctrl
    import ppc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ppc_status_t status,
    output ppc_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EVAL   = 6'b000010,
        ST_DIVIDE = 6'b000100,
        ST_MUL_HI = 6'b001000,
        ST_SCALE  = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t  state_reg, state_next;
    ppc_op_t op_reg, op_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_APPLY;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                priority if (status.edge_one) begin
                    op_next    = OP_POINT_ONE;
                    state_next = ST_EMIT;
                end else if (status.edge_two && status.diff_ok) begin
                    op_next    = OP_GAIN;
                    state_next = ST_DIVIDE;
                end else if (status.edge_two) begin
                    op_next    = OP_REJECT;
                    state_next = ST_EMIT;
                end else begin
                    op_next    = OP_APPLY;
                    state_next = ST_MUL_HI;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ppc_datapath.sv
// Datapath of the pulse position calibrator: calibration state, bit-serial gain
// divider, shared 24x32 multiplier, scaling, saturation and the result register.
// Depends on ppc_pkg.
module ppc_datapath
    import ppc_pkg::*;
#(
    parameter int POS_FRAC_BITS  = 16,
    parameter int GAIN_FRAC_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  ppc_in_t     s_data,
    input  ppc_cmd_t    cmd,
    output ppc_status_t status,
    output logic        m_valid,
    input  logic        m_ready,
    output ppc_out_t    m_data
);

    localparam int SHIFT  = GAIN_FRAC_BITS - POS_FRAC_BITS;
    localparam int GSH    = (SHIFT > 0) ? SHIFT : 0;
    localparam int LSH    = (SHIFT < 0) ? -SHIFT : 0;
    localparam int NUM_W  = 33 + GSH;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int PROD_W = 80;
    localparam int EXT_W  = PROD_W + LSH;
    localparam logic [47:0] GAIN_ONE = 48'(1) << GAIN_FRAC_BITS;
    localparam logic [48:0] CAP_POS  = 49'((64'd1 << 47) - 64'd1);
    localparam logic [48:0] CAP_NEG  = 49'(64'd1 << 47);
    localparam logic [33:0] MAG_LIM  = 34'(64'd1 << 33);

    ppc_in_t            in_reg;
    logic signed [31:0] ref_position_reg, ref_position_next;
    logic signed [31:0] ref_pulses_reg, ref_pulses_next;
    logic signed [31:0] last_position_reg, last_position_next;
    logic signed [47:0] gain_reg, gain_next;
    logic               order_one_prev_reg, order_two_prev_reg;

    logic [NUM_W-1:0]   num_reg;
    logic [31:0]        den_reg;
    logic [31:0]        rem_reg;
    logic [48:0]        quo_reg;
    logic               ovf_reg;
    logic               div_neg_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [PROD_W-1:0]  acc_reg;
    logic [33:0]        mag_reg;
    logic               mul_neg_reg;

    logic               m_valid_reg;
    ppc_out_t           m_data_reg;
    logic [1:0]         event_next;

    logic [32:0]        pdiff;
    logic [32:0]        pdiff_mag;
    logic [31:0]        idiff;
    logic [31:0]        idiff_mag;
    logic [47:0]        gain_mag;
    logic [NUM_W-1:0]   num_init;
    logic [32:0]        rem_sh;
    logic [32:0]        rem_sub;
    logic               take;
    logic [48:0]        cap;
    logic [47:0]        q_sat;
    logic [47:0]        gain_new;
    logic [23:0]        mult_a;
    logic [55:0]        mult_p;
    logic [EXT_W-1:0]   scaled;
    logic [34:0]        mag35;
    logic [34:0]        addend;
    logic [34:0]        sum35;
    logic [31:0]        sum_sat;

    assign pdiff     = {in_reg.cal_pos_two[31], in_reg.cal_pos_two}
                     - {ref_position_reg[31], ref_position_reg};
    assign pdiff_mag = pdiff[32] ? (~pdiff + 33'd1) : pdiff;
    assign idiff     = in_reg.pulse_count - ref_pulses_reg;
    assign idiff_mag = idiff[31] ? (~idiff + 32'd1) : idiff;
    assign gain_mag  = gain_reg[47] ? (~gain_reg + 48'd1) : gain_reg;
    assign num_init  = (NUM_W'(pdiff_mag) << GSH) >> LSH;

    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign take    = (rem_sh >= {1'b0, den_reg});

    assign cap      = div_neg_reg ? CAP_NEG : CAP_POS;
    assign q_sat    = (ovf_reg || (quo_reg > cap)) ? cap[47:0] : quo_reg[47:0];
    assign gain_new = div_neg_reg ? (~q_sat + 48'd1) : q_sat;

    assign mult_a = cmd.mul_hi ? gain_mag[47:24] : gain_mag[23:0];
    assign mult_p = 56'(mult_a) * 56'(idiff_mag);
    assign scaled = (EXT_W'(acc_reg) << LSH) >> GSH;

    assign mag35  = 35'(mag_reg);
    assign addend = mul_neg_reg ? (~mag35 + 35'd1) : mag35;
    assign sum35  = {{3{ref_position_reg[31]}}, ref_position_reg} + addend;

    always_comb begin
        if (!sum35[34] && (sum35[33:31] != 3'b000)) begin
            sum_sat = 32'h7FFF_FFFF;
        end else if (sum35[34] && (sum35[33:31] != 3'b111)) begin
            sum_sat = 32'h8000_0000;
        end else begin
            sum_sat = sum35[31:0];
        end
    end

    always_comb begin
        ref_position_next  = ref_position_reg;
        ref_pulses_next    = ref_pulses_reg;
        last_position_next = last_position_reg;
        gain_next          = gain_reg;
        event_next         = EVT_NONE;
        unique case (cmd.op)
            OP_POINT_ONE: begin
                ref_position_next  = in_reg.cal_pos_one;
                ref_pulses_next    = in_reg.pulse_count;
                last_position_next = in_reg.cal_pos_one;
                event_next         = EVT_POINT_ONE;
            end
            OP_GAIN: begin
                gain_next          = gain_new;
                last_position_next = in_reg.cal_pos_two;
                event_next         = EVT_POINT_TWO;
            end
            OP_REJECT: begin
                event_next = EVT_REJECT;
            end
            OP_APPLY: begin
                last_position_next = sum_sat;
                event_next         = EVT_NONE;
            end
            default: begin
                event_next = EVT_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_position_reg   <= '0;
            ref_pulses_reg     <= '0;
            last_position_reg  <= '0;
            gain_reg           <= GAIN_ONE;
            order_one_prev_reg <= 1'b0;
            order_two_prev_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cmd.commit) begin
                ref_position_reg   <= ref_position_next;
                ref_pulses_reg     <= ref_pulses_next;
                last_position_reg  <= last_position_next;
                gain_reg           <= gain_next;
                order_one_prev_reg <= in_reg.cal_order_one;
                order_two_prev_reg <= in_reg.cal_order_two;
                m_valid_reg        <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.eval) begin
            num_reg     <= num_init;
            den_reg     <= idiff_mag;
            rem_reg     <= '0;
            quo_reg     <= '0;
            ovf_reg     <= 1'b0;
            div_neg_reg <= pdiff[32] ^ idiff[31];
            cnt_reg     <= '0;
            acc_reg     <= PROD_W'(mult_p);
        end
        if (cmd.div_step) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= take ? rem_sub[31:0] : rem_sh[31:0];
            quo_reg <= {quo_reg[47:0], take};
            ovf_reg <= ovf_reg | quo_reg[48];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.mul_hi) begin
            acc_reg <= acc_reg + (PROD_W'(mult_p) << 24);
        end
        if (cmd.scale) begin
            mag_reg     <= (scaled > EXT_W'(MAG_LIM)) ? MAG_LIM : scaled[33:0];
            mul_neg_reg <= gain_reg[47] ^ idiff[31];
        end
        if (cmd.commit) begin
            m_data_reg.position  <= last_position_next;
            m_data_reg.gain_now  <= gain_next;
            m_data_reg.cal_event <= event_next;
        end
    end

    assign status.edge_one = in_reg.cal_order_one & ~order_one_prev_reg;
    assign status.edge_two = in_reg.cal_order_two & ~order_two_prev_reg;
    assign status.diff_ok  = (pdiff != '0) && (idiff != '0);
    assign status.div_last = (cnt_reg == CNT_W'(NUM_W - 1));
    assign status.out_free = ~m_valid_reg | m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hdl/pulse_position_calibrator_unit.sv
// Top level of the pulse position calibrator: two-point linear calibration of a
// raw pulse count into a Q16.16 position. Depends on ppc_pkg, ppc_ctrl, ppc_datapath.
//
// Usage: one request per scan on s_valid/s_ready/s_data carries the pulse count,
// the two calibration positions and the two order levels. Each request gives
// exactly one result on m_valid/m_ready/m_data: position, current gain and the
// calibration event. Requests are worked one at a time.
// From accept to m_valid, a point one or a rejected point two goes from evaluation
// straight to the output register; a normal scan makes two passes of a shared
// 24x32 multiplier, then scaling; and when point two sets the gain, the
// bit-serial divider paces it at one quotient bit per cycle. The next request is
// taken once the result is loaded.
// A finished result waits in the output register; a new request is accepted
// while it waits, and the block holds its next result until the receiver takes
// the pending one.
// Reset (aresetn low, synchronous) clears the reference point and last position
// to zero, sets the gain to one, clears the order history and drops m_valid.
module pulse_position_calibrator_unit
    import ppc_pkg::*;
#(
    parameter int POS_FRAC_BITS  = 16,
    parameter int GAIN_FRAC_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ppc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ppc_out_t m_data
);

    ppc_cmd_t    cmd;
    ppc_status_t status;

    ppc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ppc_datapath #(
        .POS_FRAC_BITS  (POS_FRAC_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> hdl/ppc_checker.sv
// Port-level checks for the pulse position calibrator and their bind to the top.
// Depends on ppc_pkg and pulse_position_calibrator_unit.
module ppc_checker
    import ppc_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input ppc_out_t m_data
);

    // Requests are worked one at a time, so ready drops right after an accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted in two consecutive cycles");

    // A result needs an evaluation step after its request before m_valid can rise.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared in the cycle after the request");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or was dropped");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind pulse_position_calibrator_unit ppc_checker u_ppc_checker (.*);
